/* sv/bilinear_table_interpolator_top_macros.svh */
// assertion macros for the table interpolator
`ifndef BILINEAR_TABLE_INTERPOLATOR_TOP_MACROS_SVH
`define BILINEAR_TABLE_INTERPOLATOR_TOP_MACROS_SVH
`ifndef SYNTH
`define BTI_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("bti check failed");
`define BTI_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("bti check failed");
`else
`define BTI_ASSERT_IMP(label, clk, rst, a, c)
`define BTI_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

/* sv/bti_pkg.sv */
package bti_pkg;
  localparam logic [1:0] OP_QUERY = 2'd0;
  localparam logic [1:0] OP_LOAD_MIX = 2'd1;
  localparam logic [1:0] OP_LOAD_PRS = 2'd2;
  localparam logic [1:0] OP_LOAD_GRID = 2'd3;
  localparam logic [16:0] FRAC_ONE = 17'h10000;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLAMP_LO,
    ST_CLAMP_HI,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_SEG_LO,
    ST_SEG_HI,
    ST_DIV,
    ST_AXIS_DONE,
    ST_WEIGHT,
    ST_GRID_RD,
    ST_GRID_WAIT,
    ST_MAC,
    ST_ROUND,
    ST_OUT
  } state_t;
endpackage

/* sv/bti_ram.sv */
module bti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* sv/bti_divider.sv */
// restoring divider: (num << 16) / den, one quotient bit per cycle, capped at one
module bti_divider import bti_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [16:0] quot
);
  logic [47:0] dividend;
  logic [32:0] rem;
  logic [47:0] q;
  logic [5:0]  count;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem[31:0], dividend[47]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 6'd0;
        dividend <= {num, 16'd0};
        rem <= 33'd0;
        q <= 48'd0;
      end else if (busy) begin
        dividend <= {dividend[46:0], 1'b0};
        if (!trial[32]) begin
          rem <= trial;
          q <= {q[46:0], 1'b1};
        end else begin
          rem <= {rem[31:0], dividend[47]};
          q <= {q[46:0], 1'b0};
        end
        count <= count + 6'd1;
        if (count == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // final quotient bit lands with done
  assign quot = (q[47:16] != 32'd0 || q[15:0] == 16'd0 && 1'b0) ? FRAC_ONE :
                (q > {31'd0, FRAC_ONE}) ? FRAC_ONE : q[16:0];
endmodule

/* sv/bilinear_table_interpolator_top.sv */
// table interpolator over two ascending axes and a grid of three quantities
// input channel: in_valid / in_stall with operation and payload fields;
// loads write one axis point or grid entry and give no item out
// queries give one item on out_valid / out_stall: cstar_out, cf_out, ep_out
// a load is taken on acceptance and the next item can follow right away
// a query holds the block from acceptance until its result is taken:
// per axis it clamps, scans for the segment, reads its ends and divides
// (skipped if undefined), then forms four weights, sums the corner
// products and presents the result, then goes idle before the next item;
// its length is set by the serial axis scans, the bit-serial divider used
// at most once per axis, and the shared corner multiplier used four times
// per quantity; one item is worked at a time; in_stall is high while busy
// the result stays in the output register until taken; the block holds
// in_stall high until then
// reset clears the sequencer and output valid; axes and grid stay unwritten
module bilinear_table_interpolator_top import bti_pkg::*; #(
  parameter int MIXTURE_POINTS = 16,
  parameter int PRESSURE_POINTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [3:0]         row_index,
  input  logic [3:0]         col_index,
  input  logic [31:0]        axis_value,
  input  logic signed [31:0] cstar_entry,
  input  logic signed [31:0] cf_entry,
  input  logic signed [31:0] ep_entry,
  input  logic [31:0]        query_mixture,
  input  logic [31:0]        query_pressure,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] cstar_out,
  output logic signed [31:0] cf_out,
  output logic signed [31:0] ep_out
);
  `include "bilinear_table_interpolator_top_macros.svh"

  localparam int MW = $clog2(MIXTURE_POINTS);
  localparam int PW = $clog2(PRESSURE_POINTS);
  localparam int GW = MW + PW;
  localparam int GRID = MIXTURE_POINTS * PRESSURE_POINTS;
  localparam int AW = (MW > PW) ? MW : PW;

  state_t state, state_next;

  logic accept;
  assign accept = in_valid && !in_stall;

  // axis ram ports
  logic          mix_we, prs_we;
  logic [MW-1:0] mix_ra;
  logic [PW-1:0] prs_ra;
  logic [31:0]   mix_rd, prs_rd;
  logic          row_ok, col_ok;
  assign row_ok = {1'b0, row_index} < 5'(MIXTURE_POINTS) || MW > 4;
  assign col_ok = {1'b0, col_index} < 5'(PRESSURE_POINTS) || PW > 4;

  bti_ram #(.WIDTH(32), .DEPTH(MIXTURE_POINTS)) u_mix (
    .clk, .we(mix_we), .waddr(MW'(row_index)), .wdata(axis_value),
    .raddr(mix_ra), .rdata(mix_rd));
  bti_ram #(.WIDTH(32), .DEPTH(PRESSURE_POINTS)) u_prs (
    .clk, .we(prs_we), .waddr(PW'(col_index)), .wdata(axis_value),
    .raddr(prs_ra), .rdata(prs_rd));

  logic          grid_we;
  logic [GW-1:0] grid_wa, grid_ra;
  logic [31:0]   cs_rd, cf_rd, ep_rd;
  assign grid_wa = GW'(GW'(row_index) * GW'(PRESSURE_POINTS) + GW'(col_index));

  bti_ram #(.WIDTH(32), .DEPTH(GRID)) u_cs (
    .clk, .we(grid_we), .waddr(grid_wa), .wdata(cstar_entry),
    .raddr(grid_ra), .rdata(cs_rd));
  bti_ram #(.WIDTH(32), .DEPTH(GRID)) u_cf (
    .clk, .we(grid_we), .waddr(grid_wa), .wdata(cf_entry),
    .raddr(grid_ra), .rdata(cf_rd));
  bti_ram #(.WIDTH(32), .DEPTH(GRID)) u_ep (
    .clk, .we(grid_we), .waddr(grid_wa), .wdata(ep_entry),
    .raddr(grid_ra), .rdata(ep_rd));

  assign mix_we  = accept && operation == OP_LOAD_MIX && row_ok;
  assign prs_we  = accept && operation == OP_LOAD_PRS && col_ok;
  assign grid_we = accept && operation == OP_LOAD_GRID && row_ok && col_ok;

  // working registers
  logic          axis_sel;      // 0 mixture, 1 pressure
  logic [31:0]   qm, qp, x;
  logic [AW:0]   j;             // scan index, also read address
  logic [AW-1:0] jm, kp;        // found intervals
  logic [31:0]   lo, hi;
  logic [16:0]   t, u;
  logic [1:0]    wsel;
  logic [1:0]    cnt;
  logic [1:0]    qsel;          // quantity 0..2
  logic [33:0]   w [4];
  logic signed [65:0] acc;
  logic [1:0]    sub;           // read / wait phase
  logic [31:0]   rd_axis;
  logic [AW:0]   npts;

  assign rd_axis = axis_sel ? prs_rd : mix_rd;
  assign npts = axis_sel ? (AW+1)'(PRESSURE_POINTS) : (AW+1)'(MIXTURE_POINTS);

  // divider
  logic        div_start, div_done;
  logic [16:0] div_q;
  bti_divider u_div (
    .clk, .rst, .start(div_start), .num(x - lo), .den(hi - lo),
    .done(div_done), .quot(div_q));

  // shared multipliers: weights and corner products
  logic [16:0]        ma, mb;
  logic [33:0]        wprod;
  logic signed [31:0] gval;
  logic signed [66:0] gprod;
  always_comb begin
    ma = (wsel[0] ^ wsel[1]) ? t : FRAC_ONE - t;
    ma = (wsel == 2'd1 || wsel == 2'd2) ? t : FRAC_ONE - t;
    mb = (wsel[1]) ? u : FRAC_ONE - u;
  end
  assign wprod = ma * mb;
  always_comb begin
    case (qsel)
      2'd0: gval = cs_rd;
      2'd1: gval = cf_rd;
      default: gval = ep_rd;
    endcase
  end
  assign gprod = gval * $signed({1'b0, w[cnt]});

  // grid address for corner cnt: 0 (j,k) 1 (j+1,k) 2 (j+1,k+1) 3 (j,k+1)
  logic [GW-1:0] rsel, csel;
  assign rsel = GW'(jm) + ((cnt == 2'd1 || cnt == 2'd2) ? GW'(1) : GW'(0));
  assign csel = GW'(kp) + (cnt[1] ? GW'(1) : GW'(0));
  assign grid_ra = GW'(rsel * GW'(PRESSURE_POINTS) + csel);

  always_comb begin
    mix_ra = MW'(j);
    prs_ra = PW'(j);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept && operation == OP_QUERY) state_next = ST_CLAMP_LO;
      ST_CLAMP_LO: if (sub == 2'd1) state_next = ST_CLAMP_HI;
      ST_CLAMP_HI: if (sub == 2'd1) state_next = ST_SCAN;
      ST_SCAN: state_next = ST_SCAN_WAIT;
      ST_SCAN_WAIT:
        if (!(j < npts - 1'b1 && !(x < rd_axis))) state_next = ST_SEG_LO;
        else state_next = ST_SCAN;
      ST_SEG_LO: if (sub == 2'd1) state_next = ST_SEG_HI;
      ST_SEG_HI: if (sub == 2'd1) state_next = ST_DIV;
      ST_DIV: if (div_done || hi <= lo || x < lo) state_next = ST_AXIS_DONE;
      ST_AXIS_DONE: state_next = axis_sel ? ST_WEIGHT : ST_CLAMP_LO;
      ST_WEIGHT: if (wsel == 2'd3) state_next = ST_GRID_RD;
      ST_GRID_RD: state_next = ST_GRID_WAIT;
      ST_GRID_WAIT: state_next = ST_MAC;
      ST_MAC: state_next = (cnt == 2'd3) ? ST_ROUND : ST_GRID_RD;
      ST_ROUND: state_next = (qsel == 2'd2) ? ST_OUT : ST_GRID_RD;
      ST_OUT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  assign in_stall  = state != ST_IDLE;
  assign out_valid = state == ST_OUT;

  logic div_go;
  always_comb begin
    div_go = state == ST_SEG_HI && sub == 2'd1;
  end
  logic [31:0] hi_now;
  assign hi_now = rd_axis;
  // start only when the division is defined and needed
  assign div_start = div_go && hi_now > lo && !(x < lo);

  logic signed [65:0] rnd;
  assign rnd = acc + 66'sh80000000;

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        sub <= 2'd0;
        axis_sel <= 1'b0;
        qm <= query_mixture;
        qp <= query_pressure;
        j <= '0;
      end
      ST_CLAMP_LO: begin
        if (sub == 2'd0) begin
          j <= '0;
          x <= axis_sel ? qp : qm;
          sub <= 2'd1;
        end else begin
          if (x < rd_axis) x <= rd_axis;
          j <= npts - 1'b1;
          sub <= 2'd0;
        end
      end
      ST_CLAMP_HI: begin
        if (sub == 2'd0) sub <= 2'd1;
        else begin
          if (x > rd_axis) x <= rd_axis;
          j <= (AW+1)'(1);
          sub <= 2'd0;
        end
      end
      ST_SCAN: ;
      ST_SCAN_WAIT: begin
        if (j < npts - 1'b1 && !(x < rd_axis)) j <= j + 1'b1;
        else j <= j - 1'b1;
      end
      ST_SEG_LO: begin
        if (sub == 2'd0) sub <= 2'd1;
        else begin
          lo <= rd_axis;
          if (axis_sel) kp <= AW'(j); else jm <= AW'(j);
          j <= j + 1'b1;
          sub <= 2'd0;
        end
      end
      ST_SEG_HI: begin
        if (sub == 2'd0) sub <= 2'd1;
        else begin
          hi <= rd_axis;
          sub <= 2'd0;
        end
      end
      ST_DIV: begin
        if (hi <= lo || x < lo) begin
          if (axis_sel) u <= 17'd0; else t <= 17'd0;
        end else if (div_done) begin
          if (axis_sel) u <= div_q; else t <= div_q;
        end
      end
      ST_AXIS_DONE: begin
        axis_sel <= 1'b1;
        wsel <= 2'd0;
        sub <= 2'd0;
        // second axis clamp reads point 0 first
        j <= '0;
      end
      ST_WEIGHT: begin
        w[wsel] <= wprod;
        wsel <= wsel + 2'd1;
        cnt <= 2'd0;
        qsel <= 2'd0;
        acc <= '0;
      end
      ST_GRID_RD: ;
      ST_GRID_WAIT: ;
      ST_MAC: begin
        acc <= acc + 66'(gprod);
        cnt <= cnt + 2'd1;
      end
      ST_ROUND: begin
        case (qsel)
          2'd0: cstar_out <= rnd[63:32];
          2'd1: cf_out <= rnd[63:32];
          default: ep_out <= rnd[63:32];
        endcase
        qsel <= qsel + 2'd1;
        acc <= '0;
      end
      default: ;
    endcase
  end

  `BTI_ASSERT_IMP(a_stall_busy, clk, rst, state != ST_IDLE, in_stall)
  `BTI_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(cstar_out))
  `BTI_ASSERT_IMP(a_frac_range, clk, rst, state == ST_WEIGHT, t <= FRAC_ONE && u <= FRAC_ONE)
endmodule
